FILE: design/dur_pkg.sv
// Shared types and constants for the duration string parser.
package dur_pkg;

    localparam int SEC_W = 63;
    localparam int NS_W  = 30;
    localparam int FD_W  = 4;
    localparam int UW    = 70;

    localparam logic [FD_W-1:0] FRAC_MAX = 4'd9;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BODY,
        PH_TRAIL,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_FRAC
    } fsm_t;

endpackage

FILE: design/duration_string_parser.sv
// Duration string parser: streamed [[H:]M:]S[.fraction] to seconds and nanoseconds.
//
//   channel   handshake                   payload                         transaction
//   char      char_valid / char_stall     mode, ch                        one byte or end mark
//   result    result_valid / result_stall ok, seconds, nanoseconds        one parsed duration
//
// Character transactions are taken at one byte per cycle while no end transaction runs.
// An end transaction runs the shared 70-bit adder through the weighting steps
// (times 60, add, times 60, add), then scales the fraction once per missing fraction
// digit and writes the result; no other transaction is taken until it finishes.
// Reset clears all parse state; the parse state clears again after every end transaction.
// A result waiting on result_stall does not block characters, only the next end mark.

module duration_string_parser
    import dur_pkg::*;
#(
    parameter int MAX_COMPONENTS = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  logic              mode,
    input  logic [7:0]        ch,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              ok,
    output logic [SEC_W-1:0]  seconds,
    output logic [NS_W-1:0]   nanoseconds
);

    fsm_t              state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        count_reg, count_next;
    logic [SEC_W-1:0]  cur_reg, cur_next;
    logic [SEC_W-1:0]  hist_reg [2];
    logic [SEC_W-1:0]  hist_next [2];
    logic              point_reg, point_next;
    logic [FD_W-1:0]   fdig_reg, fdig_next;
    logic [NS_W-1:0]   frac_reg, frac_next;
    logic [SEC_W-1:0]  acc_reg, acc_next;
    logic              bad_reg, bad_next;
    logic              step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              ok_reg, ok_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [NS_W-1:0]   ns_reg, ns_next;

    logic [UW-1:0]     unit_a, unit_b, unit_sum;
    logic [3:0]        unit_c;
    logic [SEC_W-1:0]  opnd;
    logic              char_fire, frac_more;
    logic              is_blank, is_digit, is_colon, is_point;
    logic              digit_ovf, take_ok, in_body;

    assign char_stall   = (state_reg != ST_IDLE) || (out_valid_reg && mode);
    assign char_fire    = char_valid && !char_stall;
    assign result_valid = out_valid_reg;
    assign ok           = ok_reg;
    assign seconds      = sec_reg;
    assign nanoseconds  = ns_reg;

    assign frac_more = point_reg && (fdig_reg < FRAC_MAX);
    assign is_blank  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_colon  = (ch == CH_COLON);
    assign is_point  = (ch == CH_POINT);
    assign in_body   = (phase_reg == PH_BODY) || ((phase_reg == PH_LEAD) && !is_blank);

    // The one arithmetic unit: a + b + c.
    assign unit_sum  = unit_a + unit_b + UW'(unit_c);
    assign digit_ovf = (unit_sum[UW-1:SEC_W] != '0);
    assign opnd      = point_reg ? SEC_W'(frac_reg) : cur_reg;

    always_comb
    begin
        if (is_digit)
        begin
            take_ok = point_reg ? (fdig_reg < FRAC_MAX) : !digit_ovf;
        end
        else if (is_colon)
        begin
            take_ok = !point_reg && (count_reg < 2'(MAX_COMPONENTS));
        end
        else if (is_point)
        begin
            take_ok = !point_reg;
        end
        else
        begin
            take_ok = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (char_fire && mode)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = step_reg ? ST_FRAC : ST_MUL;
            end
            ST_FRAC:
            begin
                state_next = frac_more ? ST_FRAC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        hist_next[0]   = hist_reg[0];
        hist_next[1]   = hist_reg[1];
        point_next     = point_reg;
        fdig_next      = fdig_reg;
        frac_next      = frac_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        step_next      = step_reg;
        ok_next        = ok_reg;
        sec_next       = sec_reg;
        ns_next        = ns_reg;
        out_valid_next = out_valid_reg && result_stall;
        unit_a         = '0;
        unit_b         = '0;
        unit_c         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                unit_a = UW'({opnd, 3'b000});
                unit_b = UW'({opnd, 1'b0});
                unit_c = ch[3:0];
                if (char_fire && mode)
                begin
                    acc_next  = hist_reg[1];
                    bad_next  = (phase_reg == PH_ERROR);
                    step_next = 1'b0;
                end
                else if (char_fire)
                begin
                    if (in_body)
                    begin
                        if (take_ok)
                        begin
                            phase_next = PH_BODY;
                            if (is_digit)
                            begin
                                if (point_reg)
                                begin
                                    frac_next = unit_sum[NS_W-1:0];
                                    fdig_next = fdig_reg + 1'b1;
                                end
                                else
                                begin
                                    cur_next = unit_sum[SEC_W-1:0];
                                    if (count_reg == 2'd0)
                                    begin
                                        count_next = 2'd1;
                                    end
                                end
                            end
                            else if (is_colon)
                            begin
                                if (count_reg == 2'd0)
                                begin
                                    count_next = 2'd1;
                                end
                                else
                                begin
                                    hist_next[1] = hist_reg[0];
                                    hist_next[0] = cur_reg;
                                    cur_next     = '0;
                                    count_next   = count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                point_next = 1'b1;
                                fdig_next  = '0;
                                frac_next  = '0;
                            end
                        end
                        else
                        begin
                            phase_next = is_blank ? PH_TRAIL : PH_ERROR;
                        end
                    end
                    else if ((phase_reg == PH_TRAIL) && !is_blank)
                    begin
                        phase_next = PH_ERROR;
                    end
                end
            end
            ST_MUL:
            begin
                // Multiply by 60 as 64x - 4x.
                unit_a   = UW'({acc_reg, 6'b000000});
                unit_b   = ~UW'({acc_reg, 2'b00});
                unit_c   = 4'd1;
                acc_next = unit_sum[SEC_W-1:0];
                if (unit_sum[UW-1:SEC_W] != '0)
                begin
                    bad_next = 1'b1;
                end
            end
            ST_ADD:
            begin
                unit_a    = UW'(acc_reg);
                unit_b    = UW'(step_reg ? cur_reg : hist_reg[0]);
                acc_next  = unit_sum[SEC_W-1:0];
                step_next = 1'b1;
                if (unit_sum[SEC_W])
                begin
                    bad_next = 1'b1;
                end
            end
            ST_FRAC:
            begin
                unit_a = UW'({frac_reg, 3'b000});
                unit_b = UW'({frac_reg, 1'b0});
                if (frac_more)
                begin
                    frac_next = unit_sum[NS_W-1:0];
                    fdig_next = fdig_reg + 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    ok_next        = !bad_reg;
                    sec_next       = bad_reg ? '0 : acc_reg;
                    ns_next        = bad_reg ? '0 : frac_reg;
                    phase_next     = PH_LEAD;
                    count_next     = '0;
                    cur_next       = '0;
                    hist_next[0]   = '0;
                    hist_next[1]   = '0;
                    point_next     = 1'b0;
                    fdig_next      = '0;
                    frac_next      = '0;
                end
            end
            default:
            begin
                unit_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LEAD;
            count_reg     <= '0;
            cur_reg       <= '0;
            hist_reg[0]   <= '0;
            hist_reg[1]   <= '0;
            point_reg     <= 1'b0;
            fdig_reg      <= '0;
            frac_reg      <= '0;
            bad_reg       <= 1'b0;
            step_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            hist_reg[0]   <= hist_next[0];
            hist_reg[1]   <= hist_next[1];
            point_reg     <= point_next;
            fdig_reg      <= fdig_next;
            frac_reg      <= frac_next;
            bad_reg       <= bad_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ok_reg  <= ok_next;
        sec_reg <= sec_next;
        ns_reg  <= ns_next;
    end

    a_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (char_fire && mode) |=> (state_reg == ST_MUL))
        else $error("End transaction did not start the weighting sequence.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !ok) |-> ((seconds == '0) && (nanoseconds == '0)))
        else $error("Failed parse reported nonzero fields.");

    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (nanoseconds < NS_W'(1000000000)))
        else $error("Nanoseconds out of range.");

    a_fdig_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fdig_reg <= FRAC_MAX)
        else $error("Fraction digit count exceeded nine.");

    a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD) |-> ((count_reg == 2'd0) && !point_reg))
        else $error("Parse state set while still in leading whitespace.");

endmodule

FILE: test/duration_string_parser_tb_pkg.sv
// Codes shared by the duration string parser testbench files.
`timescale 1ns / 100ps

package duration_tb_pkg;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

endpackage

FILE: test/duration_string_parser_checker.sv
// Checker that predicts and compares the parsed durations of the duration string parser.
`timescale 1ns / 100ps

module duration_string_parser_checker
    import dur_pkg::*, duration_tb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    input  logic             char_stall,
    input  logic             mode,
    input  logic [7:0]       ch,
    input  logic             result_valid,
    input  logic             result_stall,
    input  logic             ok,
    input  logic [SEC_W-1:0] seconds,
    input  logic [NS_W-1:0]  nanoseconds,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic             ok;
        logic [SEC_W-1:0] seconds;
        logic [NS_W-1:0]  nanoseconds;
    } duration_t;

    localparam int          COMPONENT_SLOTS    = 3;
    localparam logic [63:0] SECONDS_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SECONDS_PER_HOUR   = 64'd3600;
    localparam logic [63:0] SECONDS_PER_MINUTE = 64'd60;
    localparam logic [63:0] RADIX              = 64'd10;

    phase_t          phase_q;
    int              comp_count;
    logic [63:0]     comps [COMPONENT_SLOTS];
    logic            have_point;
    logic [FD_W-1:0] frac_digits;
    logic [31:0]     frac_value;

    duration_t expected_durations [$];
    int        mismatches = 0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_parse();
        phase_q = PH_LEAD;
        comp_count = 0;
        comps = '{default: '0};
        have_point = 1'b0;
        frac_digits = '0;
        frac_value = '0;
    endfunction

    function automatic bit accept_body_char(input logic [7:0] c);
        logic [63:0] digit;
        logic [63:0] cur;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            digit = 64'(c) - 64'(CH_ZERO);
            if (have_point)
            begin
                if (frac_digits >= FRAC_MAX)
                    return 1'b0;
                frac_digits++;
                frac_value = frac_value * 32'(RADIX) + digit[31:0];
                return 1'b1;
            end
            if (comp_count == 0)
            begin
                comp_count = 1;
                cur = '0;
            end
            else
            begin
                cur = comps[comp_count - 1];
                if (cur > (SECONDS_MAX - digit) / RADIX)
                    return 1'b0;
            end
            comps[comp_count - 1] = cur * RADIX + digit;
            return 1'b1;
        end
        if (c == CH_COLON)
        begin
            if (have_point || comp_count >= COMPONENT_SLOTS)
                return 1'b0;
            comps[comp_count] = '0;
            comp_count++;
            return 1'b1;
        end
        if (c == CH_POINT)
        begin
            if (have_point)
                return 1'b0;
            have_point = 1'b1;
            frac_digits = '0;
            frac_value = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Components are weighted from the right: seconds, minutes, hours.
    function automatic duration_t finish_duration();
        duration_t   res;
        logic [63:0] sec;
        logic [63:0] ns;
        logic [63:0] v;
        logic [63:0] weight;
        bit          good;
        int          i;
        good = (phase_q != PH_ERROR);
        sec = '0;
        ns = '0;
        for (i = 0; i < comp_count; i++)
        begin
            if (good)
            begin
                case (comp_count - 1 - i)
                    2: weight = SECONDS_PER_HOUR;
                    1: weight = SECONDS_PER_MINUTE;
                    default: weight = 64'd1;
                endcase
                v = comps[i];
                if (v > SECONDS_MAX / weight)
                    good = 1'b0;
                else
                begin
                    v = v * weight;
                    if (v > SECONDS_MAX - sec)
                        good = 1'b0;
                    else
                        sec = sec + v;
                end
            end
        end
        if (good && have_point)
        begin
            ns = 64'(frac_value);
            for (i = int'(frac_digits); i < int'(FRAC_MAX); i++)
                ns = ns * RADIX;
        end
        res.ok = good;
        res.seconds = good ? sec[SEC_W-1:0] : '0;
        res.nanoseconds = good ? ns[NS_W-1:0] : '0;
        return res;
    endfunction

    function automatic void take_transaction(input logic m, input logic [7:0] c);
        if (m == MODE_END)
        begin
            expected_durations.push_back(finish_duration());
            clear_parse();
        end
        else
        begin
            if (phase_q == PH_LEAD && !is_blank(c))
                phase_q = PH_BODY;
            case (phase_q)
                PH_BODY:
                begin
                    if (!accept_body_char(c))
                        phase_q = is_blank(c) ? PH_TRAIL : PH_ERROR;
                end
                PH_TRAIL:
                begin
                    if (!is_blank(c))
                        phase_q = PH_ERROR;
                end
                default:
                    ;
            endcase
        end
    endfunction

    function automatic void report_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endfunction

    function automatic void compare_duration();
        duration_t want;
        if (expected_durations.size() == 0)
        begin
            $display("%0t: result transaction with none expected, ok %0b seconds %0d ns %0d",
                     $time, ok, seconds, nanoseconds);
            mismatches++;
        end
        else
        begin
            want = expected_durations.pop_front();
            if (ok !== want.ok)
                report_field("ok", 64'(want.ok), 64'(ok));
            if (seconds !== want.seconds)
                report_field("seconds", 64'(want.seconds), 64'(seconds));
            if (nanoseconds !== want.nanoseconds)
                report_field("nanoseconds", 64'(want.nanoseconds), 64'(nanoseconds));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_durations.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                compare_duration();
            if (char_valid && !char_stall)
                take_transaction(mode, ch);
        end
        fail_count <= mismatches;
        pending <= expected_durations.size();
    end

endmodule

FILE: test/duration_string_parser_tb.sv
// Testbench top for the duration string parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module duration_string_parser_tb
    import dur_pkg::*, duration_tb_pkg::*;
;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             char_valid = 1'b0;
    logic             char_stall;
    logic             mode = MODE_CHAR;
    logic [7:0]       ch = 8'h00;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic             ok;
    logic [SEC_W-1:0] seconds;
    logic [NS_W-1:0]  nanoseconds;
    int               fail_count;
    int               pending;

    logic [7:0] text [$];
    int         burst_left = 0;
    int         random_items = 0;
    int         cycle_count = 0;

    always #10 clk = ~clk;

    duration_string_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .mode         (mode),
        .ch           (ch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ok           (ok),
        .seconds      (seconds),
        .nanoseconds  (nanoseconds)
    );

    duration_string_parser_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .mode         (mode),
        .ch           (ch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ok           (ok),
        .seconds      (seconds),
        .nanoseconds  (nanoseconds),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    task automatic send_transaction(input logic m, input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
        end
        char_valid <= 1'b1;
        mode <= m;
        ch <= c;
        do @(posedge clk); while (char_stall);
        burst_left--;
    endtask

    task automatic send_text(input logic [7:0] end_ch, input bit counted);
        foreach (text[i])
            send_transaction(MODE_CHAR, text[i]);
        send_transaction(MODE_END, end_ch);
        if (counted)
            random_items += text.size() + 1;
        text.delete();
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_blank();
        return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic push_blanks(input int n);
        repeat (n) text.push_back(random_blank());
    endtask

    task automatic push_digits(input int n);
        repeat (n) text.push_back(random_digit());
    endtask

    task automatic build_duration();
        int n_comp;
        int r;
        push_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 9) == 0)
            text.push_back(CH_COLON);
        n_comp = $urandom_range(0, 3);
        for (int k = 0; k < n_comp; k++)
        begin
            if (k > 0)
                text.push_back(CH_COLON);
            r = $urandom_range(0, 9);
            if (r < 7)
                push_digits($urandom_range(0, 3));
            else if (r < 9)
                push_digits($urandom_range(4, 12));
            else
                push_digits($urandom_range(13, 20));
        end
        if ($urandom_range(0, 1))
        begin
            text.push_back(CH_POINT);
            push_digits(($urandom_range(0, 9) == 0) ? 10 : $urandom_range(0, 9));
        end
        push_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    endtask

    // Values just below, at and just past the largest representable number of seconds.
    task automatic build_boundary();
        case ($urandom_range(0, 2))
            0: push_str("922337203685477580");
            1: push_str("153722867280912930:0");
            default: push_str("2562047788015215:30:0");
        endcase
        text.push_back(8'(CH_ZERO + $urandom_range(6, 9)));
        if ($urandom_range(0, 1))
        begin
            text.push_back(CH_POINT);
            push_digits($urandom_range(0, 9));
        end
    endtask

    task automatic build_broken();
        logic [7:0] c;
        int         pos;
        build_duration();
        case ($urandom_range(0, 4))
            0: c = CH_COLON;
            1: c = CH_POINT;
            2: c = random_blank();
            3: c = random_digit();
            default: c = 8'($urandom_range(0, 255));
        endcase
        if (text.size() != 0 && $urandom_range(0, 1))
            text[$urandom_range(0, text.size() - 1)] = c;
        else
        begin
            pos = $urandom_range(0, text.size());
            text.insert(pos, c);
        end
    endtask

    task automatic build_noise();
        repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        int n_strings;
        int kind;
        n_strings = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text(8'h00, 1'b0);
        push_str("\t:5. ");
        send_text(8'hFF, 1'b0);
        push_str("1 x");
        send_text(8'h5A, 1'b0);
        text.push_back(8'h00);
        send_text(8'hA5, 1'b0);
        push_str("::::");
        send_text(8'h00, 1'b0);
        push_str("..");
        send_text(8'hFF, 1'b0);
        push_str("7.");
        text.push_back(8'hFF);
        send_text(8'h00, 1'b0);
        drain_results();

        while (random_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                build_duration();
                send_text(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (kind < 72)
            begin
                build_boundary();
                send_text(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (kind < 88)
            begin
                build_broken();
                send_text(8'($urandom_range(0, 255)), 1'b1);
            end
            else
            begin
                build_noise();
                send_text(8'($urandom_range(0, 255)), 1'b1);
            end
            n_strings++;
            if (n_strings % 40 == 0)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // The result side follows its own stall pattern, with long hold-offs while characters keep
    // arriving, so that a finished transaction backs up and the block stalls the next end mark.
    initial
    begin : receiver
        int rx_cycle;
        int hold_left;
        int stall_style;
        rx_cycle = 0;
        hold_left = 0;
        stall_style = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_left == 0 && (rx_cycle == 900 || rx_cycle == 4000))
                hold_left = HOLD_CYCLES;
            if (rx_cycle % 64 == 0)
                stall_style = $urandom_range(0, 3);
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (stall_style)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 9) < 4);
                    2: result_stall <= (rx_cycle % 4 != 0);
                    default: result_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
